// ----- rtl/pidang_pkg.sv -----
// ----------------------------------------------------------------------------
// PID angle controller package
// Widths, fixed-point constants, register indexes and state encoding shared
// by the controller, its serial multiplier, its channels and its checker.
// ----------------------------------------------------------------------------
package pidang_pkg;

  localparam int ANGLE_W         = 32;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int GAIN_W          = 16;
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int STEP_TIME_FRAC  = 16;
  localparam int INTEG_W         = 48;
  localparam int TARGET_W        = 10;
  localparam int BTN_W           = 6;

  localparam int MC_W      = INTEG_W + 1;
  localparam int MUL_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);
  localparam int PROD_W    = MC_W + 1 + MUL_STEPS;
  localparam int SHP_W     = PROD_W - GAIN_FRAC_BITS;
  localparam int TSH_W     = PROD_W - STEP_TIME_FRAC;
  localparam int SUM_W     = SHP_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE     = 3'd0,
    CFG_INITIAL_TARGET = 3'd1,
    CFG_GAIN_PROP      = 3'd2,
    CFG_GAIN_INTEG     = 3'd3,
    CFG_GAIN_DERIV     = 3'd4,
    CFG_STEP_TIME      = 3'd5,
    CFG_STEP_RATE      = 3'd6
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(4915);
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(819);
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(246);
  localparam logic [GAIN_W-1:0] STEP_TIME_RST  = GAIN_W'(131);
  localparam logic [GAIN_W-1:0] STEP_RATE_RST  = GAIN_W'(500);

  localparam logic [BTN_W-1:0] BTN_UP   = BTN_W'(4);
  localparam logic [BTN_W-1:0] BTN_DOWN = BTN_W'(8);

  localparam int SETPOINT_STEP_DEG = 10;
  localparam logic signed [ANGLE_W-1:0] SETPOINT_STEP =
    ANGLE_W'(SETPOINT_STEP_DEG << ANGLE_FRAC_BITS);

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_DIFF,
    S_MUL1,
    S_START2,
    S_MUL2,
    S_SUMD,
    S_OUT
  } state_t;

endpackage

// ----- rtl/pidang_if.sv -----
// ----------------------------------------------------------------------------
// PID angle controller channels
// Valid/ready channels for sample items and for result items.
// ----------------------------------------------------------------------------
interface pidang_in_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        cmd;
  logic signed [pidang_pkg::ANGLE_W-1:0]       current_angle;
  logic        [pidang_pkg::BTN_W-1:0]         buttons;

  modport source (output valid, cmd, current_angle, buttons, input ready);
  modport sink   (input valid, cmd, current_angle, buttons, output ready);
endinterface

interface pidang_out_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [pidang_pkg::ANGLE_W-1:0]       drive_angle;
  logic signed [pidang_pkg::ANGLE_W-1:0]       error_out;
  logic signed [pidang_pkg::ANGLE_W-1:0]       setpoint_out;
  logic                                        saturated;

  modport source (output valid, drive_angle, error_out, setpoint_out, saturated,
                  input ready);
  modport sink   (input valid, drive_angle, error_out, setpoint_out, saturated,
                  output ready);
endinterface

// ----- rtl/pidang_serial_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle
// shifted out of a register while product bits shift in behind it.
// ----------------------------------------------------------------------------
module pidang_serial_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [pidang_pkg::MC_W-1:0]     mcand,
  input  logic        [pidang_pkg::MUL_STEPS-1:0] mplier,
  output logic signed [pidang_pkg::PROD_W-1:0]   prod,
  output logic                                   done
);

  localparam int MC_W      = pidang_pkg::MC_W;
  localparam int MUL_STEPS = pidang_pkg::MUL_STEPS;
  localparam int CNT_W     = pidang_pkg::CNT_W;

  logic signed [MC_W-1:0]    mcand_r;
  logic signed [MC_W:0]      acc_r, acc_nxt, sum;
  logic        [MUL_STEPS-1:0] lo_r, lo_nxt;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      busy_r;
  logic                      done_r;

  always_comb begin
    sum     = acc_r + (lo_r[0] ? (MC_W+1)'(mcand_r) : '0);
    acc_nxt = sum >>> 1;
    lo_nxt  = {sum[0], lo_r[MUL_STEPS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      acc_r   <= '0;
      lo_r    <= mplier;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign prod = $signed({acc_r, lo_r});
  assign done = done_r;

endmodule

// ----- rtl/pid_angle_controller.sv -----
// ----------------------------------------------------------------------------
// PID angle controller
// Fixed-point PID step on a measured angle with a button-adjusted setpoint.
// ----------------------------------------------------------------------------
// Sample items arrive on in_ch and results leave on out_ch, both valid/ready;
// a transfer happens on a clock edge with valid and ready high. Registers are
// written through cfg_we, cfg_index and cfg_wdata, one per edge.
// A clear item or a sample item with run mode off is absorbed in idle and
// gives no result. A sample item in run mode takes the block through the
// error step, a start step, a round of three bit-serial multipliers, a second
// start step, a round of two, a sum and saturation step and the output step;
// the next item is taken only once the block is back in idle.
// The result sits in an output register; if the receiver stalls, the next
// finished result waits in the output step and the block holds in_ch.ready
// low until the output register is free.
// Reset is synchronous: it clears the state, the output valid, the setpoint,
// the last error and the integrator, and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_angle_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  pidang_in_if.sink                             in_ch,
  pidang_out_if.source                          out_ch,
  input  logic                                  cfg_we,
  input  logic [pidang_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidang_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ANGLE_W   = pidang_pkg::ANGLE_W;
  localparam int INTEG_W   = pidang_pkg::INTEG_W;
  localparam int GAIN_W    = pidang_pkg::GAIN_W;
  localparam int MC_W      = pidang_pkg::MC_W;
  localparam int PROD_W    = pidang_pkg::PROD_W;
  localparam int SHP_W     = pidang_pkg::SHP_W;
  localparam int TSH_W     = pidang_pkg::TSH_W;
  localparam int SUM_W     = pidang_pkg::SUM_W;
  localparam int IS_W      = TSH_W + 1;
  localparam int GFB       = pidang_pkg::GAIN_FRAC_BITS;
  localparam int STF       = pidang_pkg::STEP_TIME_FRAC;

  pidang_pkg::state_t state_r, state_nxt;

  logic                                  run_enable_r;
  logic [pidang_pkg::TARGET_W-1:0]       initial_target_r;
  logic [GAIN_W-1:0]                     gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [GAIN_W-1:0]                     step_time_r, step_rate_r;

  logic signed [ANGLE_W-1:0]             setpoint_r, last_error_r;
  logic signed [INTEG_W-1:0]             integ_r;

  logic signed [ANGLE_W-1:0]             angle_r, err_r, drive_r;
  logic [pidang_pkg::BTN_W-1:0]          btn_r;
  logic signed [INTEG_W-1:0]             integ_new_r, dr_r;
  logic signed [SUM_W-1:0]               sum_r;
  logic                                  flag_r;

  logic                                  out_valid_r;
  logic signed [ANGLE_W-1:0]             out_drive_r, out_err_r, out_sp_r;
  logic                                  out_sat_r;

  logic                                  in_ready;
  logic                                  mul_start;
  logic                                  phase2;
  logic                                  out_load;
  logic                                  accept;

  logic signed [MC_W-1:0]                mc0, mc1, mc2;
  logic [GAIN_W-1:0]                     mp0, mp1;
  logic signed [PROD_W-1:0]              prod0, prod1, prod2;
  logic                                  done0, done1, done2;

  logic signed [ANGLE_W:0]               err_diff, diff;
  logic                                  err_ovf;
  logic signed [ANGLE_W-1:0]             err_nxt;
  logic signed [TSH_W-1:0]               t_val;
  logic signed [IS_W-1:0]                integ_sum;
  logic                                  integ_ovf;
  logic signed [INTEG_W-1:0]             integ_nxt;
  logic                                  dr_ovf;
  logic signed [INTEG_W-1:0]             dr_nxt;
  logic signed [SHP_W-1:0]               term0, term1;
  logic signed [SUM_W-1:0]               sum_p, sum_i, sum_d;
  logic                                  drive_ovf;
  logic signed [ANGLE_W-1:0]             drive_nxt;
  logic                                  sp_move;
  logic signed [ANGLE_W:0]               sp_sum;
  logic                                  sp_ovf;
  logic signed [ANGLE_W-1:0]             setpoint_nxt;

  assign accept = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidang_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    phase2    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      pidang_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && !in_ch.cmd && run_enable_r) begin
          state_nxt = pidang_pkg::S_ERR;
        end
      end
      pidang_pkg::S_ERR: begin
        state_nxt = pidang_pkg::S_DIFF;
      end
      pidang_pkg::S_DIFF: begin
        mul_start = 1'b1;
        state_nxt = pidang_pkg::S_MUL1;
      end
      pidang_pkg::S_MUL1: begin
        if (done0 && done1 && done2) begin
          state_nxt = pidang_pkg::S_START2;
        end
      end
      pidang_pkg::S_START2: begin
        mul_start = 1'b1;
        phase2    = 1'b1;
        state_nxt = pidang_pkg::S_MUL2;
      end
      pidang_pkg::S_MUL2: begin
        if (done0 && done1) begin
          state_nxt = pidang_pkg::S_SUMD;
        end
      end
      pidang_pkg::S_SUMD: begin
        state_nxt = pidang_pkg::S_OUT;
      end
      pidang_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = pidang_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pidang_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r     <= 1'b0;
      initial_target_r <= '0;
      gain_prop_r      <= pidang_pkg::GAIN_PROP_RST;
      gain_integ_r     <= pidang_pkg::GAIN_INTEG_RST;
      gain_deriv_r     <= pidang_pkg::GAIN_DERIV_RST;
      step_time_r      <= pidang_pkg::STEP_TIME_RST;
      step_rate_r      <= pidang_pkg::STEP_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidang_pkg::CFG_RUN_ENABLE:     run_enable_r     <= cfg_wdata[0];
        pidang_pkg::CFG_INITIAL_TARGET: initial_target_r <= cfg_wdata[pidang_pkg::TARGET_W-1:0];
        pidang_pkg::CFG_GAIN_PROP:      gain_prop_r      <= cfg_wdata[GAIN_W-1:0];
        pidang_pkg::CFG_GAIN_INTEG:     gain_integ_r     <= cfg_wdata[GAIN_W-1:0];
        pidang_pkg::CFG_GAIN_DERIV:     gain_deriv_r     <= cfg_wdata[GAIN_W-1:0];
        pidang_pkg::CFG_STEP_TIME:      step_time_r      <= cfg_wdata[GAIN_W-1:0];
        pidang_pkg::CFG_STEP_RATE:      step_rate_r      <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    diff = (ANGLE_W+1)'(err_r) - (ANGLE_W+1)'(last_error_r);
    if (phase2) begin
      mc0 = MC_W'(integ_new_r);
      mp0 = gain_integ_r;
      mc1 = MC_W'(dr_r);
      mp1 = gain_deriv_r;
    end else begin
      mc0 = MC_W'(err_r);
      mp0 = gain_prop_r;
      mc1 = MC_W'(err_r);
      mp1 = step_time_r;
    end
    mc2 = MC_W'(diff);
  end

  pidang_serial_mul u_mul0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mc0),
    .mplier (mp0),
    .prod   (prod0),
    .done   (done0)
  );

  pidang_serial_mul u_mul1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mc1),
    .mplier (mp1),
    .prod   (prod1),
    .done   (done1)
  );

  pidang_serial_mul u_mul2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start && !phase2),
    .mcand  (mc2),
    .mplier (step_rate_r),
    .prod   (prod2),
    .done   (done2)
  );

  always_comb begin
    err_diff = (ANGLE_W+1)'(setpoint_r) - (ANGLE_W+1)'(angle_r);
    err_ovf  = err_diff[ANGLE_W] != err_diff[ANGLE_W-1];
    if (err_ovf) begin
      err_nxt = err_diff[ANGLE_W] ? pidang_pkg::ANGLE_MIN : pidang_pkg::ANGLE_MAX;
    end else begin
      err_nxt = err_diff[ANGLE_W-1:0];
    end

    t_val     = $signed(prod1[PROD_W-1:STF]);
    integ_sum = IS_W'(integ_r) + IS_W'(t_val);
    integ_ovf = !((&integ_sum[IS_W-1:INTEG_W-1]) || !(|integ_sum[IS_W-1:INTEG_W-1]));
    if (integ_ovf) begin
      integ_nxt = integ_sum[IS_W-1] ? pidang_pkg::INTEG_MIN : pidang_pkg::INTEG_MAX;
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end

    dr_ovf = !((&prod2[PROD_W-1:INTEG_W-1]) || !(|prod2[PROD_W-1:INTEG_W-1]));
    if (dr_ovf) begin
      dr_nxt = prod2[PROD_W-1] ? pidang_pkg::INTEG_MIN : pidang_pkg::INTEG_MAX;
    end else begin
      dr_nxt = prod2[INTEG_W-1:0];
    end

    term0 = $signed(prod0[PROD_W-1:GFB]);
    term1 = $signed(prod1[PROD_W-1:GFB]);
    sum_p = SUM_W'(angle_r) + SUM_W'(term0);
    sum_i = sum_r + SUM_W'(term0);
    sum_d = sum_r + SUM_W'(term1);

    drive_ovf = !((&sum_d[SUM_W-1:ANGLE_W-1]) || !(|sum_d[SUM_W-1:ANGLE_W-1]));
    if (drive_ovf) begin
      drive_nxt = sum_d[SUM_W-1] ? pidang_pkg::ANGLE_MIN : pidang_pkg::ANGLE_MAX;
    end else begin
      drive_nxt = sum_d[ANGLE_W-1:0];
    end

    sp_move = (btn_r == pidang_pkg::BTN_UP) || (btn_r == pidang_pkg::BTN_DOWN);
    if (btn_r == pidang_pkg::BTN_DOWN) begin
      sp_sum = (ANGLE_W+1)'(setpoint_r) - (ANGLE_W+1)'(pidang_pkg::SETPOINT_STEP);
    end else begin
      sp_sum = (ANGLE_W+1)'(setpoint_r) + (ANGLE_W+1)'(pidang_pkg::SETPOINT_STEP);
    end
    sp_ovf = sp_sum[ANGLE_W] != sp_sum[ANGLE_W-1];
    if (!sp_move) begin
      setpoint_nxt = setpoint_r;
    end else if (sp_ovf) begin
      setpoint_nxt = sp_sum[ANGLE_W] ? pidang_pkg::ANGLE_MIN : pidang_pkg::ANGLE_MAX;
    end else begin
      setpoint_nxt = sp_sum[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= '0;
      last_error_r <= '0;
      integ_r      <= '0;
    end else if (accept && in_ch.cmd) begin
      setpoint_r   <= ANGLE_W'({initial_target_r, {pidang_pkg::ANGLE_FRAC_BITS{1'b0}}});
      last_error_r <= '0;
      integ_r      <= '0;
    end else if (state_r == pidang_pkg::S_SUMD) begin
      setpoint_r   <= setpoint_nxt;
      last_error_r <= err_r;
      integ_r      <= integ_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      angle_r <= in_ch.current_angle;
      btn_r   <= in_ch.buttons;
      flag_r  <= 1'b0;
    end
    if (state_r == pidang_pkg::S_ERR) begin
      err_r  <= err_nxt;
      flag_r <= err_ovf;
    end
    if (state_r == pidang_pkg::S_MUL1 && done0) begin
      integ_new_r <= integ_nxt;
      dr_r        <= dr_nxt;
      sum_r       <= sum_p;
      flag_r      <= flag_r || integ_ovf || dr_ovf;
    end
    if (state_r == pidang_pkg::S_MUL2 && done0) begin
      sum_r <= sum_i;
    end
    if (state_r == pidang_pkg::S_SUMD) begin
      drive_r <= drive_nxt;
      flag_r  <= flag_r || drive_ovf || (sp_move && sp_ovf);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive_r <= drive_r;
      out_err_r   <= err_r;
      out_sp_r    <= setpoint_r;
      out_sat_r   <= flag_r;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_angle  = out_drive_r;
  assign out_ch.error_out    = out_err_r;
  assign out_ch.setpoint_out = out_sp_r;
  assign out_ch.saturated    = out_sat_r;

endmodule

// ----- rtl/pidang_checker.sv -----
// ----------------------------------------------------------------------------
// PID angle controller checker
// Port-level assertions on the result channel and on item acceptance.
// ----------------------------------------------------------------------------
module pidang_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_cmd,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [pidang_pkg::ANGLE_W-1:0] out_drive_angle,
  input logic signed [pidang_pkg::ANGLE_W-1:0] out_error_out,
  input logic signed [pidang_pkg::ANGLE_W-1:0] out_setpoint_out,
  input logic                                  out_saturated,
  input logic                                  cfg_we,
  input logic [pidang_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [pidang_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic run_mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mirror_r <= 1'b0;
    end else if (cfg_we && cfg_index == pidang_pkg::CFG_RUN_ENABLE) begin
      run_mirror_r <= cfg_wdata[0];
    end
  end

  a_out_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result valid dropped before its transfer.");

  a_out_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_drive_angle) && $stable(out_error_out)
      && $stable(out_setpoint_out) && $stable(out_saturated))
    else $error("Result payload changed while stalled.");

  a_clear_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> in_ready)
    else $error("Clear item did not complete in one cycle.");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd && run_mirror_r |=> !in_ready)
    else $error("Input accepted while a sample is in progress.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("Result appeared right after an input transfer.");

endmodule

bind pid_angle_controller pidang_checker u_pidang_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_cmd           (in_ch.cmd),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_drive_angle  (out_ch.drive_angle),
  .out_error_out    (out_ch.error_out),
  .out_setpoint_out (out_ch.setpoint_out),
  .out_saturated    (out_ch.saturated),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_wdata        (cfg_wdata)
);

// ----- bench/tb_pid_angle_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID angle controller testbench
// Drives sample and clear items into the controller and checks each result
// against a fixed-point PID predictor in the bench or typed row values.
// A short table of directed rows comes first. A calm run of button presses
// then walks the setpoint up and back down. Random phases with random
// register settings and random idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_pid_angle_controller;

  localparam int ANGLE_W         = pidang_pkg::ANGLE_W;
  localparam int ANGLE_FRAC_BITS = pidang_pkg::ANGLE_FRAC_BITS;
  localparam int GAIN_W          = pidang_pkg::GAIN_W;
  localparam int GAIN_FRAC_BITS  = pidang_pkg::GAIN_FRAC_BITS;
  localparam int STEP_TIME_FRAC  = pidang_pkg::STEP_TIME_FRAC;
  localparam int INTEG_W         = pidang_pkg::INTEG_W;
  localparam int TARGET_W        = pidang_pkg::TARGET_W;
  localparam int BTN_W           = pidang_pkg::BTN_W;
  localparam int CFG_IDX_W       = pidang_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = pidang_pkg::CFG_DATA_W;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 50;
  localparam int STALL_LIMIT    = 3000;
  localparam int ITEM_TOTAL     = 1950;
  localparam int IDLE_PCT       = 15;
  localparam int CALM_CLIMB     = 200;
  localparam int NEAR_SPAN      = 80 << ANGLE_FRAC_BITS;
  localparam int TARGET_TOP     = 999;
  localparam int WORD_TOP       = 65535;
  localparam longint SP_MOVE    = longint'(10) << ANGLE_FRAC_BITS;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam logic [GAIN_W-1:0] KP_DEFAULT   = pidang_pkg::GAIN_PROP_RST;
  localparam logic [GAIN_W-1:0] KI_DEFAULT   = pidang_pkg::GAIN_INTEG_RST;
  localparam logic [GAIN_W-1:0] KD_DEFAULT   = pidang_pkg::GAIN_DERIV_RST;
  localparam logic [GAIN_W-1:0] DT_DEFAULT   = pidang_pkg::STEP_TIME_RST;
  localparam logic [GAIN_W-1:0] RATE_DEFAULT = pidang_pkg::STEP_RATE_RST;

  typedef struct packed {
    logic                      cmd;
    logic signed [ANGLE_W-1:0] angle;
    logic [BTN_W-1:0]          buttons;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] drive;
    logic signed [ANGLE_W-1:0] err;
    logic signed [ANGLE_W-1:0] setp;
    logic                      sat;
  } pid_result_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               item;
    logic                  typed;
    pid_result_t           typed_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pidang_in_if  in_ch();
  pidang_out_if out_ch();

  pid_angle_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic run_on;
  logic [TARGET_W-1:0] target;
  logic [GAIN_W-1:0] kp, ki, kd, dt, rate;
  logic signed [ANGLE_W-1:0] setpoint_q, prev_err;
  logic signed [INTEG_W-1:0] integ_q;

  pid_result_t pending_q[$];
  stim_row_t rows[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int sent = 0;
  logic calm = 1'b0;
  logic settled = 1'b1;

  always #CLK_HALF clk = ~clk;

  function automatic longint clip(longint v, int bits, inout logic hit);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      hit = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      pidang_pkg::CFG_RUN_ENABLE:     run_on = data[0];
      pidang_pkg::CFG_INITIAL_TARGET: target = data[TARGET_W-1:0];
      pidang_pkg::CFG_GAIN_PROP:      kp = data;
      pidang_pkg::CFG_GAIN_INTEG:     ki = data;
      pidang_pkg::CFG_GAIN_DERIV:     kd = data;
      pidang_pkg::CFG_STEP_TIME:      dt = data;
      pidang_pkg::CFG_STEP_RATE:      rate = data;
      default: ;
    endcase
  endfunction

  // Returns 1 when the item produces a result; updates the controller state.
  function automatic logic pid_step(sample_t s, output pid_result_t r);
    longint ang, e, diff, integ, p, iv, d, drv, sp;
    longint lkp, lki, lkd, ldt, lrate, ltarget;
    logic hit;
    r = '0;
    hit = 1'b0;
    lkp = longint'(kp);
    lki = longint'(ki);
    lkd = longint'(kd);
    ldt = longint'(dt);
    lrate = longint'(rate);
    ltarget = longint'(target);
    if (s.cmd == CMD_CLEAR) begin
      setpoint_q = ANGLE_W'(clip(ltarget << ANGLE_FRAC_BITS, ANGLE_W, hit));
      prev_err = '0;
      integ_q = '0;
      return 1'b0;
    end
    if (!run_on) return 1'b0;
    ang = longint'(s.angle);
    sp = longint'(setpoint_q);
    e = clip(sp - ang, ANGLE_W, hit);
    diff = clip((e - longint'(prev_err)) * lrate, INTEG_W, hit);
    prev_err = ANGLE_W'(e);
    integ = clip(longint'(integ_q) + ((e * ldt) >>> STEP_TIME_FRAC), INTEG_W, hit);
    integ_q = INTEG_W'(integ);
    p = (lkp * e) >>> GAIN_FRAC_BITS;
    iv = (lki * integ) >>> GAIN_FRAC_BITS;
    d = (lkd * diff) >>> GAIN_FRAC_BITS;
    drv = clip(ang + p + iv + d, ANGLE_W, hit);
    if (s.buttons == pidang_pkg::BTN_UP) begin
      sp = clip(sp + SP_MOVE, ANGLE_W, hit);
    end else if (s.buttons == pidang_pkg::BTN_DOWN) begin
      sp = clip(sp - SP_MOVE, ANGLE_W, hit);
    end
    setpoint_q = ANGLE_W'(sp);
    r.drive = ANGLE_W'(drv);
    r.err = ANGLE_W'(e);
    r.setp = setpoint_q;
    r.sat = hit;
    return 1'b1;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    rows.push_back(row);
  endfunction

  function automatic void add_item(logic cmd, logic signed [ANGLE_W-1:0] angle,
                                   logic [BTN_W-1:0] buttons);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.cmd = cmd;
    row.item.angle = angle;
    row.item.buttons = buttons;
    rows.push_back(row);
  endfunction

  function automatic void add_typed(logic signed [ANGLE_W-1:0] angle, logic [BTN_W-1:0] buttons,
                                    logic signed [ANGLE_W-1:0] drive,
                                    logic signed [ANGLE_W-1:0] err,
                                    logic signed [ANGLE_W-1:0] setp, logic sat);
    add_item(CMD_SAMPLE, angle, buttons);
    rows[$].typed = 1'b1;
    rows[$].typed_res.drive = drive;
    rows[$].typed_res.err = err;
    rows[$].typed_res.setp = setp;
    rows[$].typed_res.sat = sat;
  endfunction

  function automatic int near_offset();
    return int'($urandom_range(NEAR_SPAN)) - NEAR_SPAN / 2;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 30) return CFG_DATA_W'(WORD_TOP);
    if (pick < 60) return CFG_DATA_W'($urandom_range(8191));
    return CFG_DATA_W'($urandom_range(WORD_TOP));
  endfunction

  function automatic sample_t next_sample();
    sample_t s;
    int unsigned pick;
    s.cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_SAMPLE;
    pick = $urandom_range(99);
    if (pick < 55) begin
      s.angle = setpoint_q + near_offset();
    end else if (pick < 85) begin
      s.angle = $urandom();
    end else begin
      case ($urandom_range(3))
        0: s.angle = pidang_pkg::ANGLE_MIN;
        1: s.angle = pidang_pkg::ANGLE_MAX;
        2: s.angle = '0;
        default: s.angle = -1;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      s.buttons = pidang_pkg::BTN_UP;
    end else if (pick < 60) begin
      s.buttons = pidang_pkg::BTN_DOWN;
    end else if (pick < 70) begin
      s.buttons = '0;
    end else begin
      s.buttons = BTN_W'($urandom_range(63));
    end
    return s;
  endfunction

  function automatic void check_field(string name, logic signed [ANGLE_W-1:0] want,
                                      logic signed [ANGLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Registers change only once the controller has gone quiet.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    if (!settled) begin
      while (pending_q.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      settled = 1'b1;
    end
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put_item(sample_t s, logic typed, pid_result_t typed_res);
    pid_result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= s.cmd;
    in_ch.current_angle <= s.angle;
    in_ch.buttons <= s.buttons;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    settled = 1'b0;
    sent++;
    if (pid_step(s, r)) begin
      pending_q.push_back(typed ? typed_res : r);
    end
  endtask

  always @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : check_results
    pid_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, drive_angle %0d", $time,
                 out_ch.drive_angle);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        check_field("drive_angle", want.drive, out_ch.drive_angle);
        check_field("error_out", want.err, out_ch.error_out);
        check_field("setpoint_out", want.setp, out_ch.setpoint_out);
        check_field("saturated", ANGLE_W'(want.sat), ANGLE_W'(out_ch.saturated));
      end
    end
  end

  // The watchdog counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_t s;
    int phase, len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pidang_pkg::CFG_RUN_ENABLE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SAMPLE;
    in_ch.current_angle = '0;
    in_ch.buttons = '0;
    out_ch.ready = 1'b0;

    run_on = 1'b0;
    target = '0;
    kp = KP_DEFAULT;
    ki = KI_DEFAULT;
    kd = KD_DEFAULT;
    dt = DT_DEFAULT;
    rate = RATE_DEFAULT;
    setpoint_q = '0;
    prev_err = '0;
    integ_q = '0;

    add_item(CMD_SAMPLE, 32'sh0005_0000, pidang_pkg::BTN_UP);
    add_reg(pidang_pkg::CFG_RUN_ENABLE, 16'd1);
    add_typed('0, '0, '0, '0, '0, 1'b0);
    add_typed('0, pidang_pkg::BTN_UP, '0, '0, ANGLE_W'(SP_MOVE), 1'b0);
    add_item(CMD_SAMPLE, '0, pidang_pkg::BTN_DOWN);
    add_item(CMD_SAMPLE, 32'sh0014_0000, pidang_pkg::BTN_UP | pidang_pkg::BTN_DOWN);
    add_item(CMD_SAMPLE, 32'sh1234_5678, 6'h3F);
    add_item(CMD_SAMPLE, -1, pidang_pkg::BTN_UP | 6'h01);
    add_reg(CFG_UNUSED, 16'hFFFF);
    add_item(CMD_SAMPLE, 32'sh0003_0000, pidang_pkg::BTN_DOWN);
    add_reg(pidang_pkg::CFG_GAIN_PROP, '0);
    add_reg(pidang_pkg::CFG_GAIN_INTEG, '0);
    add_reg(pidang_pkg::CFG_GAIN_DERIV, '0);
    add_reg(pidang_pkg::CFG_STEP_RATE, '0);
    add_item(CMD_CLEAR, pidang_pkg::ANGLE_MAX, pidang_pkg::BTN_UP);
    add_typed(pidang_pkg::ANGLE_MIN, '0, pidang_pkg::ANGLE_MIN, pidang_pkg::ANGLE_MAX, '0,
              1'b1);
    add_typed(pidang_pkg::ANGLE_MAX, '0, pidang_pkg::ANGLE_MAX, pidang_pkg::ANGLE_MIN + 1, '0,
              1'b0);
    add_reg(pidang_pkg::CFG_GAIN_PROP, CFG_DATA_W'(WORD_TOP));
    add_reg(pidang_pkg::CFG_GAIN_INTEG, CFG_DATA_W'(WORD_TOP));
    add_reg(pidang_pkg::CFG_GAIN_DERIV, CFG_DATA_W'(WORD_TOP));
    add_reg(pidang_pkg::CFG_STEP_TIME, CFG_DATA_W'(WORD_TOP));
    add_reg(pidang_pkg::CFG_STEP_RATE, CFG_DATA_W'(WORD_TOP));
    add_reg(pidang_pkg::CFG_INITIAL_TARGET, CFG_DATA_W'(TARGET_TOP));
    add_item(CMD_CLEAR, '0, '0);
    add_item(CMD_SAMPLE, pidang_pkg::ANGLE_MIN, pidang_pkg::BTN_DOWN);
    add_item(CMD_SAMPLE, pidang_pkg::ANGLE_MAX, pidang_pkg::BTN_UP);
    add_item(CMD_SAMPLE, '0, 6'h3F);
    add_reg(pidang_pkg::CFG_STEP_RATE, 16'd1);
    add_reg(pidang_pkg::CFG_STEP_TIME, '0);
    add_item(CMD_SAMPLE, 32'sh0001_0000, pidang_pkg::BTN_DOWN);
    add_item(CMD_SAMPLE, 32'shFFFF_0000, 6'h2A);
    add_reg(pidang_pkg::CFG_RUN_ENABLE, '0);
    add_item(CMD_CLEAR, pidang_pkg::ANGLE_MAX, 6'h15);
    add_item(CMD_SAMPLE, 32'sh0005_0000, pidang_pkg::BTN_UP);
    add_reg(pidang_pkg::CFG_RUN_ENABLE, 16'd1);
    add_item(CMD_SAMPLE, '0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_REG) begin
        put_reg(rows[k].idx, rows[k].data);
      end else begin
        put_item(rows[k].item, rows[k].typed, rows[k].typed_res);
      end
    end

    // Walk the setpoint up and back down with button presses, with no idling on either side.
    put_reg(pidang_pkg::CFG_GAIN_PROP, KP_DEFAULT);
    put_reg(pidang_pkg::CFG_GAIN_INTEG, KI_DEFAULT);
    put_reg(pidang_pkg::CFG_GAIN_DERIV, KD_DEFAULT);
    put_reg(pidang_pkg::CFG_STEP_TIME, DT_DEFAULT);
    put_reg(pidang_pkg::CFG_STEP_RATE, RATE_DEFAULT);
    s = '0;
    s.cmd = CMD_CLEAR;
    put_item(s, 1'b0, '0);
    calm = 1'b1;
    s.cmd = CMD_SAMPLE;
    repeat (CALM_CLIMB) begin
      s.angle = setpoint_q + near_offset();
      s.buttons = pidang_pkg::BTN_UP;
      put_item(s, 1'b0, '0);
    end
    repeat (12) begin
      s.angle = setpoint_q + near_offset();
      s.buttons = pidang_pkg::BTN_DOWN;
      put_item(s, 1'b0, '0);
    end
    calm = 1'b0;

    phase = 0;
    while (sent < ITEM_TOTAL) begin
      calm = (phase == 4);
      if ($urandom_range(1)) begin
        put_reg(pidang_pkg::CFG_RUN_ENABLE, CFG_DATA_W'($urandom_range(99) < 85));
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(2))
          0: put_reg(pidang_pkg::CFG_INITIAL_TARGET, '0);
          1: put_reg(pidang_pkg::CFG_INITIAL_TARGET, CFG_DATA_W'(TARGET_TOP));
          default: put_reg(pidang_pkg::CFG_INITIAL_TARGET,
                           CFG_DATA_W'($urandom_range(TARGET_TOP)));
        endcase
      end
      if ($urandom_range(1)) put_reg(pidang_pkg::CFG_GAIN_PROP, pick_word());
      if ($urandom_range(1)) put_reg(pidang_pkg::CFG_GAIN_INTEG, pick_word());
      if ($urandom_range(1)) put_reg(pidang_pkg::CFG_GAIN_DERIV, pick_word());
      if ($urandom_range(1)) put_reg(pidang_pkg::CFG_STEP_TIME, pick_word());
      if ($urandom_range(1)) put_reg(pidang_pkg::CFG_STEP_RATE, pick_word());
      if ($urandom_range(1)) begin
        s = next_sample();
        s.cmd = CMD_CLEAR;
        put_item(s, 1'b0, '0);
      end
      len = $urandom_range(10, 80);
      repeat (len) put_item(next_sample(), 1'b0, '0);
      phase++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
